// File: rtl/prqd_pkg.sv
// Package for the priority ready-queue dispatcher.
// Holds queue entry type, command and status codes, and controller/datapath structs.
// No dependencies.
`default_nettype none
package prqd_pkg;

  // operation codes of an input item
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_REMOVE   = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [3:0] id;
    logic [2:0] pri;
  } entry_t;

  // how returning read data is used
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_MATCH,
    MODE_MIN,
    MODE_SHIFT
  } dp_mode_e;

  // write port source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW,
    WR_AT_TGT,
    WR_TAIL,
    WR_HEAD
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic       latch;        // capture id and priority of the accepted item
    logic       scan_start;   // load scan pointer
    logic       scan_from_one;
    logic       shift_start;  // load pointer with target + 1
    logic       rd_en;
    dp_mode_e   mode;
    wr_sel_e    wr_sel;
    cnt_op_e    cnt_op;
    logic       out_load;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic single;
    logic full;
    logic rd_more;  // pointer still below the entry count
    logic rd_vld;
    logic hit;
    logic last;
    logic better;
    logic equal;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/prqd_req_if.sv
// Request channel of the dispatcher: valid/ready handshake and command payload.
// No dependencies.
`default_nettype none
interface prqd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] task_id;
  logic [2:0] task_priority;
  logic       rotate;

  modport source (output valid, cmd, task_id, task_priority, rotate, input ready);
  modport sink   (input valid, cmd, task_id, task_priority, rotate, output ready);
endinterface
`default_nettype wire

// File: rtl/prqd_rsp_if.sv
// Result channel of the dispatcher: valid/ready handshake and result payload.
// CNT_W must equal $clog2(MAX_TASKS + 1) of the dispatcher.
`default_nettype none
interface prqd_rsp_if #(
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [3:0]       running_id;
  logic [CNT_W-1:0] occupancy;

  modport source (output valid, status, running_id, occupancy, input ready);
  modport sink   (input valid, status, running_id, occupancy, output ready);
endinterface
`default_nettype wire

// File: rtl/prqd_dpath.sv
// Datapath of the dispatcher: queue memory, head copy, scan pointer, best tracker,
// entry count and result register. Uses prqd_pkg; driven by prqd_ctrl.
`default_nettype none
module prqd_dpath #(
  parameter int MAX_TASKS = 16,
  parameter int AW        = $clog2(MAX_TASKS),
  parameter int CW        = $clog2(MAX_TASKS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [3:0]        task_id_i,
  input  wire logic [2:0]        task_priority_i,
  input  wire prqd_pkg::dp_cmd_t cmd_i,
  output prqd_pkg::dp_stat_t     stat_o,
  output logic [1:0]             status_o,
  output logic [3:0]             running_id_o,
  output logic [CW-1:0]          occupancy_o
);

  prqd_pkg::entry_t mem [MAX_TASKS];

  prqd_pkg::entry_t new_q, head_q, best_q, rd_data_q;
  prqd_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_idx_q, tgt_q, wr_addr;
  logic [CW-1:0]    idx_q, count_q, count_m1;
  logic             rd_vld_q, best_vld_q, wr_en;
  logic [1:0]       status_q;
  logic [3:0]       running_id_q;
  logic [CW-1:0]    occupancy_q;

  assign count_m1 = count_q - CW'(1);

  // write port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = head_q;
    case (cmd_i.wr_sel)
      prqd_pkg::WR_SHIFT: begin
        wr_en   = rd_vld_q;
        wr_addr = rd_idx_q - AW'(1);
        wr_data = rd_data_q;
      end
      prqd_pkg::WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = count_q[AW-1:0];
        wr_data = new_q;
      end
      prqd_pkg::WR_AT_TGT: begin
        wr_en   = 1'b1;
        wr_addr = tgt_q;
        wr_data = head_q;
      end
      prqd_pkg::WR_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = count_m1[AW-1:0];
        wr_data = head_q;
      end
      prqd_pkg::WR_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = best_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // queue memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
      rd_idx_q  <= idx_q[AW-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      new_q <= '{id: task_id_i, pri: task_priority_i};
    end
    if (wr_en && wr_addr == '0) begin
      head_q <= wr_data;
    end
    if (rd_vld_q && cmd_i.mode == prqd_pkg::MODE_MATCH && stat_o.hit) begin
      tgt_q <= rd_idx_q;
    end
    if (rd_vld_q && cmd_i.mode == prqd_pkg::MODE_MIN &&
        (!best_vld_q || rd_data_q.pri < best_q.pri)) begin
      best_q <= rd_data_q;
      tgt_q  <= rd_idx_q;
    end
    if (cmd_i.out_load) begin
      status_q     <= cmd_i.status;
      running_id_q <= (count_q != '0) ? head_q.id : 4'd0;
      occupancy_q  <= count_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.scan_start) begin
        idx_q      <= cmd_i.scan_from_one ? CW'(1) : '0;
        best_vld_q <= 1'b0;
      end else if (cmd_i.shift_start) begin
        idx_q <= CW'(tgt_q) + CW'(1);
      end else if (cmd_i.rd_en) begin
        idx_q <= idx_q + CW'(1);
      end
      if (rd_vld_q && cmd_i.mode == prqd_pkg::MODE_MIN) begin
        best_vld_q <= 1'b1;
      end
      case (cmd_i.cnt_op)
        prqd_pkg::CNT_INC: count_q <= count_q + CW'(1);
        prqd_pkg::CNT_DEC: count_q <= count_m1;
        default:           count_q <= count_q;
      endcase
    end
  end

  always_comb begin
    stat_o.empty   = (count_q == '0);
    stat_o.single  = (count_q == CW'(1));
    stat_o.full    = (count_q == CW'(MAX_TASKS));
    stat_o.rd_more = (idx_q < count_q);
    stat_o.rd_vld  = rd_vld_q;
    stat_o.hit     = rd_vld_q && (rd_data_q.id == new_q.id);
    stat_o.last    = rd_vld_q && (CW'(rd_idx_q) == count_m1);
    stat_o.better  = (best_q.pri < head_q.pri);
    stat_o.equal   = (best_q.pri == head_q.pri);
  end

  assign status_o     = status_q;
  assign running_id_o = running_id_q;
  assign occupancy_o  = occupancy_q;

endmodule
`default_nettype wire

// File: rtl/prqd_ctrl.sv
// Controller of the dispatcher: sequences search, minimum scan, shift and writes.
// Uses prqd_pkg; commands prqd_dpath.
`default_nettype none
module prqd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire logic [1:0]         req_cmd_i,
  input  wire logic               req_rotate_i,
  output logic                    rsp_valid_o,
  input  wire logic               rsp_ready_i,
  input  wire prqd_pkg::dp_stat_t stat_i,
  output prqd_pkg::dp_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRCH   = 4'd1;
  localparam logic [3:0] S_MIN    = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_PREP   = 4'd4;
  localparam logic [3:0] S_SHIFT  = 4'd5;
  localparam logic [3:0] S_SWAP   = 4'd6;
  localparam logic [3:0] S_TAIL   = 4'd7;
  localparam logic [3:0] S_HEAD   = 4'd8;
  localparam logic [3:0] S_NEW    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       rot_q, rot_d;
  logic [1:0] st_q, st_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rot_d       = rot_q;
    st_d        = st_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o       = '{latch: 1'b0, scan_start: 1'b0, scan_from_one: 1'b0,
                    shift_start: 1'b0, rd_en: 1'b0, mode: prqd_pkg::MODE_NONE,
                    wr_sel: prqd_pkg::WR_NONE, cnt_op: prqd_pkg::CNT_HOLD,
                    out_load: 1'b0, status: st_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          op_d        = req_cmd_i;
          rot_d       = req_rotate_i;
          st_d        = prqd_pkg::ST_OK;
          state_d     = S_FIN;
          case (req_cmd_i)
            prqd_pkg::CMD_INSERT: begin
              if (stat_i.full) begin
                st_d = prqd_pkg::ST_FULL;
              end else if (stat_i.empty) begin
                state_d = S_NEW;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = S_SRCH;
              end
            end
            prqd_pkg::CMD_REMOVE: begin
              if (stat_i.empty) begin
                st_d = prqd_pkg::ST_NOT_FOUND;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = S_SRCH;
              end
            end
            prqd_pkg::CMD_DISPATCH: begin
              if (stat_i.empty) begin
                st_d = prqd_pkg::ST_EMPTY;
              end else if (!stat_i.single) begin
                cmd_o.scan_start    = 1'b1;
                cmd_o.scan_from_one = 1'b1;
                state_d             = S_MIN;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_SRCH: begin
        cmd_o.mode  = prqd_pkg::MODE_MATCH;
        cmd_o.rd_en = stat_i.rd_more && !stat_i.hit;
        if (stat_i.hit) begin
          state_d = (op_q == prqd_pkg::CMD_REMOVE) ? S_PREP : S_FIN;
        end else if (stat_i.last) begin
          if (op_q == prqd_pkg::CMD_REMOVE) begin
            st_d    = prqd_pkg::ST_NOT_FOUND;
            state_d = S_FIN;
          end else begin
            state_d = S_NEW;
          end
        end
      end
      S_MIN: begin
        cmd_o.mode  = prqd_pkg::MODE_MIN;
        cmd_o.rd_en = stat_i.rd_more;
        if (stat_i.last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.better) begin
          state_d = S_SWAP;
        end else if (rot_q && stat_i.equal) begin
          cmd_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_PREP: begin
        cmd_o.shift_start = 1'b1;
        state_d           = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.mode   = prqd_pkg::MODE_SHIFT;
        cmd_o.rd_en  = stat_i.rd_more;
        cmd_o.wr_sel = prqd_pkg::WR_SHIFT;
        if (!stat_i.rd_more && !stat_i.rd_vld) begin
          if (op_q == prqd_pkg::CMD_REMOVE) begin
            cmd_o.cnt_op = prqd_pkg::CNT_DEC;
            state_d      = S_FIN;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_SWAP: begin
        cmd_o.wr_sel = prqd_pkg::WR_AT_TGT;
        state_d      = S_HEAD;
      end
      S_TAIL: begin
        cmd_o.wr_sel = prqd_pkg::WR_TAIL;
        state_d      = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.wr_sel = prqd_pkg::WR_HEAD;
        state_d      = S_FIN;
      end
      S_NEW: begin
        cmd_o.wr_sel = prqd_pkg::WR_NEW;
        cmd_o.cnt_op = prqd_pkg::CNT_INC;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= prqd_pkg::CMD_INSERT;
      rot_q       <= 1'b0;
      st_q        <= prqd_pkg::ST_OK;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      rot_q       <= rot_d;
      st_q        <= st_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/priority_ready_queue_dispatcher.sv
// Priority ready-queue dispatcher: a queue of (task id, priority) entries, entry 0
// running. Request channel req_i: cmd insert / remove / dispatch, task_id,
// task_priority, rotate. Result channel rsp_o: status, running_id, occupancy.
// One result item per request item, in order.
// Works on one item at a time: req_i.ready is high only while idle.
// Full insert, remove/dispatch on empty, single-entry dispatch and the unused command go
// from accept straight to the result state. Every entry visit is one read of the queue
// memory (one read, one write port), so the search, the minimum scan and the gap-closing
// shift visit the entries one after another. Entry 0 is mirrored in a register so the
// running id is always at hand.
// Reset empties the queue (count to zero); memory contents are not cleared and
// need no clearing pass, as only entries below the count are ever read.
// The result sits in an output register; while rsp_o.ready is low the result is
// held and a finished item waits in its last state until the register frees.
// Uses prqd_pkg, prqd_req_if, prqd_rsp_if, prqd_ctrl and prqd_dpath.
`default_nettype none
module priority_ready_queue_dispatcher #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  prqd_req_if.sink   req_i,
  prqd_rsp_if.source rsp_o
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  prqd_pkg::dp_cmd_t  dp_cmd;
  prqd_pkg::dp_stat_t dp_stat;
  logic [CW-1:0]      occupancy;

  // sequencing: one item from accept to result
  prqd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_cmd_i    (req_i.cmd),
    .req_rotate_i (req_i.rotate),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd)
  );

  // queue storage, scan and result register
  prqd_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .AW        (AW),
    .CW        (CW)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .task_id_i       (req_i.task_id),
    .task_priority_i (req_i.task_priority),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .status_o        (rsp_o.status),
    .running_id_o    (rsp_o.running_id),
    .occupancy_o     (occupancy)
  );

  assign rsp_o.occupancy = occupancy;

endmodule
`default_nettype wire

// File: bench/tb_priority_ready_queue_dispatcher.sv
`timescale 1ns / 100ps
// Self-checking bench for the priority ready-queue dispatcher: directed and random
// command traffic with random idling on both channels, results checked in order.
// Depends on prqd_pkg, prqd_req_if, prqd_rsp_if and priority_ready_queue_dispatcher.
module tb_priority_ready_queue_dispatcher;

  localparam int MAX_TASKS = 16;
  localparam int CNT_W     = 5;
  // cmd 3 has no name in the package; the block must treat it as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // worst accept-to-result time is a dispatch over a full queue
  localparam int TAIL_CYCLES = 2 * MAX_TASKS + 8;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       running_id;
    logic [CNT_W-1:0] occupancy;
  } sched_result_t;

  logic clk;
  logic rst_n;

  prqd_req_if                 req_if ();
  prqd_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

  priority_ready_queue_dispatcher #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Own copy of the ready queue: entry 0 is the running task.
  logic [3:0] rq_id  [MAX_TASKS];
  logic [2:0] rq_pri [MAX_TASKS];
  int         rq_count;

  // Results predicted at request accept, oldest first.
  sched_result_t pending_results[$];

  int unsigned mismatch_count;
  bit          calm_mode;   // when set neither side idles
  int          stall_left;

  always #5 clk = ~clk;

  // Idle length: half the time none, mostly short, now and then a long one.
  function automatic int draw_gap();
    int r;
    if (calm_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Take entry k out of line and put it at position rq_count-1,
  // the entries after k moving down by one.
  function automatic void rotate_to_tail(int k);
    logic [3:0] hold_id;
    logic [2:0] hold_pri;
    hold_id  = rq_id[k];
    hold_pri = rq_pri[k];
    for (int j = k + 1; j < rq_count; j++) begin
      rq_id[j-1]  = rq_id[j];
      rq_pri[j-1] = rq_pri[j];
    end
    rq_id[rq_count-1]  = hold_id;
    rq_pri[rq_count-1] = hold_pri;
  endfunction

  // Apply one command to the queue copy and return the result it must produce.
  function automatic sched_result_t apply_queue_op(logic [1:0] cmd, logic [3:0] id,
                                                   logic [2:0] pri, logic rot);
    sched_result_t res;
    int            best;
    int            hit;
    logic [3:0]    tmp_id;
    logic [2:0]    tmp_pri;
    res.status = prqd_pkg::ST_OK;
    hit        = -1;
    case (cmd)
      prqd_pkg::CMD_INSERT: begin
        // full is checked before the duplicate search
        if (rq_count >= MAX_TASKS) begin
          res.status = prqd_pkg::ST_FULL;
        end else begin
          for (int k = 0; k < rq_count; k++)
            if (rq_id[k] == id && hit < 0) hit = k;
          // a queued id keeps its old priority
          if (hit < 0) begin
            rq_id[rq_count]  = id;
            rq_pri[rq_count] = pri;
            rq_count++;
          end
        end
      end
      prqd_pkg::CMD_REMOVE: begin
        for (int k = 0; k < rq_count; k++)
          if (rq_id[k] == id && hit < 0) hit = k;
        if (hit < 0) begin
          res.status = prqd_pkg::ST_NOT_FOUND;
        end else begin
          rotate_to_tail(hit);
          rq_count--;
        end
      end
      prqd_pkg::CMD_DISPATCH: begin
        if (rq_count == 0) begin
          res.status = prqd_pkg::ST_EMPTY;
        end else if (rq_count > 1) begin
          // first entry past the head with the lowest number wins
          best = 1;
          for (int k = 2; k < rq_count; k++)
            if (rq_pri[k] < rq_pri[best]) best = k;
          if (rq_pri[best] < rq_pri[0] || (rot && rq_pri[best] == rq_pri[0])) begin
            tmp_id       = rq_id[0];
            tmp_pri      = rq_pri[0];
            rq_id[0]     = rq_id[best];
            rq_pri[0]    = rq_pri[best];
            rq_id[best]  = tmp_id;
            rq_pri[best] = tmp_pri;
            // equal priority with rotate: old runner goes to the back
            if (rq_pri[best] == rq_pri[0]) rotate_to_tail(best);
          end
        end
      end
      default: ;
    endcase
    res.running_id = (rq_count > 0) ? rq_id[0] : 4'd0;
    res.occupancy  = rq_count[CNT_W-1:0];
    return res;
  endfunction

  // Present one request item and hold it until accepted. Valid is only lowered
  // when a gap follows, so back-to-back items keep it high across the edge.
  task automatic issue_command(logic [1:0] cmd, logic [3:0] id, logic [2:0] pri,
                               logic rot);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.cmd           <= cmd;
    req_if.task_id       <= id;
    req_if.task_priority <= pri;
    req_if.rotate        <= rot;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(apply_queue_op(cmd, id, pri, rot));
  endtask

  // Result side: ready drops for random stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      stall_left = draw_gap();
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: status %0d running_id %0d occupancy %0d",
                 $time, rsp_if.status, rsp_if.running_id, rsp_if.occupancy);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.running_id !== want.running_id) begin
          $display("%0t: running_id expected %0d actual %0d", $time, want.running_id,
                   rsp_if.running_id);
          mismatch_count++;
        end
        if (rsp_if.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   rsp_if.occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // Commands on an empty queue, the unused code among them.
  task automatic test_empty_queue();
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b0);
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd15, 3'd7, 1'b1);
    issue_command(prqd_pkg::CMD_REMOVE, 4'd7, 3'd0, 1'b0);
    issue_command(CMD_UNUSED, 4'd0, 3'd0, 1'b0);
  endtask

  // Hand-picked sequence through duplicates, swap, rotation and removal.
  task automatic test_ordering_rules();
    issue_command(prqd_pkg::CMD_INSERT, 4'd5, 3'd3, 1'b0);
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b1);   // single entry
    issue_command(prqd_pkg::CMD_INSERT, 4'd5, 3'd1, 1'b0);     // duplicate, pri kept
    issue_command(prqd_pkg::CMD_INSERT, 4'd15, 3'd7, 1'b0);    // top id, pri 7
    issue_command(prqd_pkg::CMD_INSERT, 4'd0, 3'd0, 1'b0);     // pri 0
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b0);   // more urgent: swap
    issue_command(prqd_pkg::CMD_INSERT, 4'd9, 3'd0, 1'b0);
    issue_command(prqd_pkg::CMD_INSERT, 4'd2, 3'd0, 1'b0);
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b0);   // equal, no rotate
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b1);   // equal, rotate
    issue_command(prqd_pkg::CMD_REMOVE, 4'd15, 3'd0, 1'b0);    // middle entry
    issue_command(prqd_pkg::CMD_REMOVE, 4'd15, 3'd0, 1'b0);    // now absent
    issue_command(prqd_pkg::CMD_REMOVE, 4'd9, 3'd0, 1'b0);     // head
    issue_command(prqd_pkg::CMD_INSERT, 4'd14, 3'd7, 1'b0);
    issue_command(prqd_pkg::CMD_INSERT, 4'd3, 3'd6, 1'b0);
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b1);
    issue_command(CMD_UNUSED, 4'd15, 3'd7, 1'b1);              // all bits high
    issue_command(prqd_pkg::CMD_REMOVE, 4'd3, 3'd0, 1'b0);     // tail
  endtask

  // Fill to capacity, hit the full case with two ids that are both queued,
  // then dispatch and drain completely.
  task automatic test_full_queue();
    for (int k = 0; k < MAX_TASKS; k++)
      issue_command(prqd_pkg::CMD_INSERT, 4'(k), 3'($urandom_range(1, 3)), 1'b0);
    issue_command(prqd_pkg::CMD_INSERT, 4'd4, 3'd1, 1'b0);
    issue_command(prqd_pkg::CMD_INSERT, 4'd11, 3'd0, 1'b1);
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b0);
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b1);
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b1);
    for (int k = MAX_TASKS - 1; k >= 0; k--)
      issue_command(prqd_pkg::CMD_REMOVE, 4'(k), 3'd0, 1'b0);
    issue_command(prqd_pkg::CMD_DISPATCH, 4'd0, 3'd0, 1'b1);
  endtask

  // Random command mix. Most removes name a queued id, so the search and the
  // gap-closing shift run over real entries; priorities mostly in [pri_lo, pri_hi].
  task automatic test_random_traffic(int n_items, int ins_pct, int rem_pct,
                                     int pri_lo, int pri_hi);
    int         r;
    logic [3:0] id;
    logic [2:0] pri;
    for (int n = 0; n < n_items; n++) begin
      r   = $urandom_range(0, 99);
      id  = 4'($urandom_range(0, 15));
      pri = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(pri_lo, pri_hi));
      if (r < ins_pct) begin
        issue_command(prqd_pkg::CMD_INSERT, id, pri, 1'($urandom_range(0, 1)));
      end else if (r < ins_pct + rem_pct) begin
        if (rq_count > 0 && $urandom_range(0, 3) != 0)
          id = rq_id[$urandom_range(0, rq_count - 1)];
        issue_command(prqd_pkg::CMD_REMOVE, id, pri, 1'($urandom_range(0, 1)));
      end else if (r < 97) begin
        issue_command(prqd_pkg::CMD_DISPATCH, id, pri, 1'($urandom_range(0, 1)));
      end else begin
        issue_command(CMD_UNUSED, id, pri, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.cmd           = prqd_pkg::CMD_INSERT;
    req_if.task_id       = 4'd0;
    req_if.task_priority = 3'd0;
    req_if.rotate        = 1'b0;
    rsp_if.ready         = 1'b0;
    rq_count             = 0;
    mismatch_count       = 0;
    calm_mode            = 1'b0;
    stall_left           = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_ordering_rules();
    test_full_queue();
    test_random_traffic(300, 40, 25, 1, 6);   // balanced
    test_random_traffic(250, 40, 20, 2, 3);   // few levels: many ties and rotations
    test_random_traffic(300, 65, 10, 1, 6);   // mostly near full
    test_random_traffic(200, 20, 45, 1, 6);   // mostly near empty
    calm_mode = 1'b1;
    test_random_traffic(100, 45, 25, 1, 4);   // back to back, no idling
    calm_mode = 1'b0;

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hang guard, well above the slowest legal run.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/prqd_pkg.sv
rtl/prqd_req_if.sv
rtl/prqd_rsp_if.sv
rtl/prqd_dpath.sv
rtl/prqd_ctrl.sv
rtl/priority_ready_queue_dispatcher.sv
bench/tb_priority_ready_queue_dispatcher.sv
